// ----- rtl/deadline_timer_queue_macros.svh -----
// Assertion macros shared by the deadline timer queue checkers.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dtq_pkg.sv -----
// Types and constants shared by the deadline timer queue modules.
package dtq_pkg;

   localparam int NOW_W    = 64;
   localparam int SECS_W   = 16;
   localparam int HANDLE_W = 8;
   localparam int FREQ_W   = 32;
   localparam int KIND_W   = 2;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
   localparam logic [NOW_W-1:0]  ALL_ONES   = 64'hffff_ffff_ffff_ffff;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_EXPIRE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

   typedef struct packed {
      logic                func;
      logic [NOW_W-1:0]    now;
      logic [SECS_W-1:0]   delay_seconds;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] fired_handle;
      logic [NOW_W-1:0]    compare_value;
      logic                compare_changed;
      logic                full_error;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WALK,
      ST_EXPIRE,
      ST_FINAL
   } state_type;

endpackage

// ----- rtl/dtq_mac.sv -----
// Shift-and-add unit that forms now + delay_seconds * tick_frequency, one bit a cycle.
module dtq_mac
   import dtq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NOW_W-1:0]  now,
   input  logic [SECS_W-1:0] secs,
   input  logic [FREQ_W-1:0] freq,
   output logic              done,
   output logic [NOW_W-1:0]  result
);

   localparam int STEP_W = $clog2(SECS_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SECS_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NOW_W-1:0]  acc_ff, acc_in;
   logic [NOW_W-1:0]  fsh_ff, fsh_in;
   logic [SECS_W-1:0] ssh_ff, ssh_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      fsh_in  = fsh_ff;
      ssh_in  = ssh_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = now;
         fsh_in  = NOW_W'(freq);
         ssh_in  = secs;
      end else if (busy_ff) begin
         if (ssh_ff[0]) begin
            acc_in = acc_ff + fsh_ff;
         end
         fsh_in  = {fsh_ff[NOW_W-2:0], 1'b0};
         ssh_in  = {1'b0, ssh_ff[SECS_W-1:1]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      acc_ff  <= acc_in;
      fsh_ff  <= fsh_in;
      ssh_ff  <= ssh_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- rtl/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: sorted timer store, sequencer and result register.
// An add transaction is accepted, passes through the shift-and-add multiplier, then the
// insertion walk, which moves later entries aside one by one and writes the new one, and
// then presents its result. An add to a full queue skips the multiplier and the walk.
// An expire transaction is accepted, emits one result per fired timer, finds the first
// later deadline and presents the final result. The store has a single read and a single
// write port, which sets the one-entry-per-cycle pace of both walks while the result side
// does not stall the expire walk. Stalls on the result side add cycles.
module deadline_timer_queue
   import dtq_pkg::*;
#(
   parameter int TIMER_SLOTS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [FREQ_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(TIMER_SLOTS);
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lg);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(lg);
      if (s >= SUM_W'(TIMER_SLOTS)) begin
         s = s - SUM_W'(TIMER_SLOTS);
      end
      return s[IDX_W-1:0];
   endfunction

   logic [NOW_W-1:0]    dl_mem [TIMER_SLOTS];
   logic [HANDLE_W-1:0] hd_mem [TIMER_SLOTS];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [FREQ_W-1:0]   freq_ff;
   logic [NOW_W-1:0]    now_ff, now_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                chg_ff, chg_in;
   logic                full_ff, full_in;
   logic                expire_ff, expire_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                mac_start;
   logic                mac_done;
   logic [NOW_W-1:0]    mac_result;

   logic [CNT_W-1:0]    rd_lg;
   logic [IDX_W-1:0]    rd_idx;
   logic [NOW_W-1:0]    rd_dl_ff;
   logic [HANDLE_W-1:0] rd_hd_ff;
   logic                out_free;
   logic                walk_stop;
   logic                due;
   logic                add_full;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [NOW_W-1:0]    wr_dl;
   logic [HANDLE_W-1:0] wr_hd;
   logic                emit;
   rsp_type             emit_data;

   dtq_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .now    (req_data.now),
      .secs   (req_data.delay_seconds),
      .freq   (freq_ff),
      .done   (mac_done),
      .result (mac_result)
   );

   assign rd_lg     = ((state_in == ST_WALK) && (pos_in != '0)) ? pos_in - CNT_W'(1) : '0;
   assign rd_idx    = phys(head_in, rd_lg);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_stop = (pos_ff == '0) || (rd_dl_ff < mac_result);
   assign due       = (count_ff != '0) && (rd_dl_ff <= now_ff);
   assign add_full  = (count_ff == SLOTS_C);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_EXPIRE) begin
                  state_in = ST_EXPIRE;
               end else if (add_full) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mac_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               state_in = ST_FINAL;
            end
         end
         ST_EXPIRE: begin
            if (!due) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mac_start = 1'b0;
      wr_en     = 1'b0;
      wr_idx    = phys(head_ff, pos_ff);
      wr_dl     = rd_dl_ff;
      wr_hd     = rd_hd_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      chg_in    = chg_ff;
      full_in   = full_ff;
      expire_in = expire_ff;
      now_in    = now_ff;
      handle_in = handle_ff;
      emit      = 1'b0;
      emit_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in    = req_data.now;
               handle_in = req_data.handle;
               expire_in = (req_data.func == FUNC_EXPIRE);
               full_in   = (req_data.func == FUNC_ADD) && add_full;
               chg_in    = (req_data.func == FUNC_EXPIRE);
               mac_start = (req_data.func == FUNC_ADD) && !add_full;
            end
         end
         ST_MUL: begin
            if (mac_done) begin
               pos_in = count_ff;
            end
         end
         ST_WALK: begin
            wr_en = 1'b1;
            if (walk_stop) begin
               wr_dl    = mac_result;
               wr_hd    = handle_ff;
               count_in = count_ff + CNT_W'(1);
               chg_in   = (pos_ff == '0);
            end else begin
               pos_in = pos_ff - CNT_W'(1);
            end
         end
         ST_EXPIRE: begin
            if (due && out_free) begin
               emit                   = 1'b1;
               emit_data.kind         = KIND_FIRED;
               emit_data.fired_handle = rd_hd_ff;
               head_in                = phys(head_ff, CNT_W'(1));
               count_in               = count_ff - CNT_W'(1);
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit                      = 1'b1;
               emit_data.kind            = expire_ff ? KIND_NEXT : KIND_ADD;
               emit_data.compare_value   = (count_ff == '0) ? ALL_ONES :
                                           (!expire_ff && chg_ff) ? mac_result : rd_dl_ff;
               emit_data.compare_changed = chg_ff;
               emit_data.full_error      = full_ff;
               emit_data.last            = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_idx] <= wr_dl;
         hd_mem[wr_idx] <= wr_hd;
      end
      rd_dl_ff <= dl_mem[rd_idx];
      rd_hd_ff <= hd_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         freq_ff      <= FREQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         if (csr_valid) begin
            freq_ff <= csr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      pos_ff    <= pos_in;
      now_ff    <= now_in;
      handle_ff <= handle_in;
      chg_ff    <= chg_in;
      full_ff   <= full_in;
      expire_ff <= expire_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/dtq_checker.sv -----
// Port-level assertions for the deadline timer queue and the bind that attaches them.
`include "deadline_timer_queue_macros.svh"

module dtq_checker
   import dtq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `DTQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "Result changed while stalled.")
   `DTQ_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "Second transaction accepted while one is in progress.")
   `DTQ_ASSERT(a_fired_shape, clock, reset, rsp_valid && (rsp_data.kind == KIND_FIRED) |-> !rsp_data.last && (rsp_data.compare_value == '0), "Fired result is marked last or carries a compare value.")
   `DTQ_ASSERT(a_next_shape, clock, reset, rsp_valid && (rsp_data.kind == KIND_NEXT) |-> rsp_data.last && rsp_data.compare_changed, "Next compare result is not last or not marked changed.")
   `DTQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "Result valid right after reset.")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
